FILE: hw/rtl/sktkp_pkg.sv
// shared types and constants for the scored top-k pair retainer
// no dependencies
`default_nettype none
package sktkp_pkg;
  localparam int MAX_RETAINED = 16;
  localparam int IDX_W  = $clog2(MAX_RETAINED);
  localparam int FILL_W = $clog2(MAX_RETAINED + 1);
  localparam int DVD_W  = 35;
  localparam int DVS_W  = 32;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int KEY_W  = 35 + 45 + 32;

  typedef struct packed {
    logic        kind;
    logic [15:0] software_rank;
    logic [15:0] system_rank;
    logic [31:0] actor_count;
    logic [31:0] graph_count;
    logic [31:0] memory_root_count;
    logic [31:0] core_count;
    logic [31:0] transport_count;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [15:0] out_software_rank;
    logic [15:0] out_system_rank;
    logic [34:0] wave_bound;
    logic [44:0] work_score;
    logic [31:0] offered_total;
    logic [31:0] dropped_total;
    logic        last;
  } out_item_t;

  // sort key: waves, work, software rank, system rank, compared as one word
  typedef struct packed {
    logic [34:0] waves;
    logic [44:0] work;
    logic [31:0] rank;
  } key_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_status_t;

  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
endpackage
`default_nettype wire

FILE: hw/rtl/sktkp_divider.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on sktkp_pkg
`default_nettype none
module sktkp_divider import sktkp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output div_status_t           status
);
  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r, done_r;
  logic [DVS_W:0]   rem_sh, rem_sub;

  assign rem_sh  = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DVD_W);
        dvd_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        quo_r <= '0;
      end else if (run_r) begin
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= rem_sub;
          quo_r <= {quo_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[DVD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign status.done     = done_r;
  assign status.quotient = quo_r;
endmodule
`default_nettype wire

FILE: hw/rtl/scored_top_k_pair_retainer_core.sv
// top level: sequencer, retained-pair table, shared key comparator
// depends on sktkp_pkg and sktkp_divider
`default_nettype none
// An offered pair keeps busy high through the 35 wave division steps, the
// hand-over of the quotient and the scoring; once the table is full the
// worst-entry scan over every retained entry and a decide step follow. A
// flush keeps busy high through one table scan per emitted pair through
// the single key comparator, and each result shows on out_valid for one
// cycle; the receiver cannot stall, so results must be taken as they come.
// An empty flush gives one result with entry_valid low, in the cycle after
// it is taken, and busy stays low. cfg_we sets the pair limit limit_r (reset 16).
module scored_top_k_pair_retainer_core import sktkp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [4:0] cfg_data
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SCORE, ST_SCAN, ST_DECIDE, ST_FSCAN, ST_FEMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [4:0]             limit_r;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [31:0]            offered_r, offered_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       sel_r, sel_nxt;
  logic [FILL_W-1:0]      emit_cnt_r, emit_cnt_nxt;
  logic [MAX_RETAINED-1:0] emitted_r, emitted_nxt;
  logic                   have_r, have_nxt;
  key_t                   sel_key_r, sel_key_nxt;
  key_t                   cand_r, cand_nxt;
  in_item_t               item_r;
  logic                   out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  key_t                   table_q [MAX_RETAINED];
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  key_t                   rd_key;
  logic [IDX_W-1:0]       rd_idx;

  key_t                   cmp_a, cmp_b;
  logic                   a_lt_b;
  logic [FILL_W-1:0]      lim;
  logic [31:0]            dropped;
  logic [DVD_W-1:0]       load;
  logic [DVS_W-1:0]       cap;
  logic                   div_start;
  div_status_t            div_st;
  logic [44:0]            work;

  sktkp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (load),
    .divisor  (cap),
    .status   (div_st)
  );

  assign lim = (32'(limit_r) > MAX_RETAINED) ? FILL_W'(MAX_RETAINED) : FILL_W'(limit_r);
  assign cap = (in_item.core_count == '0) ? DVS_W'(1) : in_item.core_count;
  assign load = DVD_W'(in_item.actor_count) + {2'b0, in_item.graph_count, 1'b0}
              + {2'b0, in_item.memory_root_count, 1'b0} + DVD_W'(cap) - DVD_W'(1);
  assign div_start = (state_r == ST_IDLE) && start && (in_item.kind == KIND_OFFER);
  assign work = {div_st.quotient, 10'b0}
              + {10'b0, item_r.actor_count, 3'b0}
              + {9'b0, item_r.graph_count, 4'b0}
              + {8'b0, item_r.memory_root_count, 5'b0}
              + {11'b0, item_r.transport_count, 2'b0};
  assign dropped = (offered_r >= 32'(fill_r)) ? offered_r - 32'(fill_r) : '0;

  assign rd_idx = (state_r == ST_FEMIT) ? sel_r : idx_r;
  assign rd_key = table_q[rd_idx];

  // single shared comparator, strictly-before on the packed key
  always_comb begin
    cmp_a = sel_key_r;
    cmp_b = rd_key;
    unique case (state_r)
      ST_DECIDE: begin cmp_a = cand_r;  cmp_b = sel_key_r; end
      ST_FSCAN:  begin cmp_a = rd_key;  cmp_b = sel_key_r; end
      default:   begin cmp_a = sel_key_r; cmp_b = rd_key; end
    endcase
  end
  assign a_lt_b = cmp_a < cmp_b;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    offered_nxt   = offered_r;
    idx_nxt       = idx_r;
    sel_nxt       = sel_r;
    sel_key_nxt   = sel_key_r;
    cand_nxt      = cand_r;
    have_nxt      = have_r;
    emitted_nxt   = emitted_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_idx        = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.kind == KIND_OFFER) begin
            state_nxt = ST_DIV;
            if (offered_r != '1) offered_nxt = offered_r + 32'd1;
          end else if (fill_r == '0) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
            out_item_nxt.offered_total = offered_r;
            out_item_nxt.dropped_total = dropped;
            out_item_nxt.last = 1'b1;
            offered_nxt = '0;
          end else begin
            state_nxt    = ST_FSCAN;
            idx_nxt      = '0;
            have_nxt     = 1'b0;
            emitted_nxt  = '0;
            emit_cnt_nxt = '0;
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        cand_nxt.waves = div_st.quotient;
        cand_nxt.work  = work;
        cand_nxt.rank  = {item_r.software_rank, item_r.system_rank};
        if (fill_r < lim) begin
          wr_en     = 1'b1;
          wr_idx    = IDX_W'(fill_r);
          fill_nxt  = fill_r + FILL_W'(1);
          state_nxt = ST_IDLE;
        end else if (fill_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = '0;
          have_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!have_r || a_lt_b) begin
          sel_nxt     = idx_r;
          sel_key_nxt = rd_key;
        end
        have_nxt = 1'b1;
        idx_nxt  = idx_r + IDX_W'(1);
        if (FILL_W'(idx_r) == fill_r - FILL_W'(1)) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        wr_idx = sel_r;
        wr_en  = a_lt_b;
        state_nxt = ST_IDLE;
      end
      ST_FSCAN: begin
        if (!emitted_r[idx_r] && (!have_r || a_lt_b)) begin
          sel_nxt     = idx_r;
          sel_key_nxt = rd_key;
          have_nxt    = 1'b1;
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (FILL_W'(idx_r) == fill_r - FILL_W'(1)) state_nxt = ST_FEMIT;
      end
      ST_FEMIT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt.entry_valid       = 1'b1;
        out_item_nxt.out_software_rank = rd_key.rank[31:16];
        out_item_nxt.out_system_rank   = rd_key.rank[15:0];
        out_item_nxt.wave_bound        = rd_key.waves;
        out_item_nxt.work_score        = rd_key.work;
        out_item_nxt.offered_total     = offered_r;
        out_item_nxt.dropped_total     = dropped;
        out_item_nxt.last              = (emit_cnt_r == fill_r - FILL_W'(1));
        emitted_nxt[sel_r] = 1'b1;
        emit_cnt_nxt = emit_cnt_r + FILL_W'(1);
        idx_nxt  = '0;
        have_nxt = 1'b0;
        if (emit_cnt_r == fill_r - FILL_W'(1)) begin
          fill_nxt    = '0;
          offered_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_FSCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      limit_r    <= 5'd16;
      fill_r     <= '0;
      offered_r  <= '0;
      out_valid  <= 1'b0;
      have_r     <= 1'b0;
      emitted_r  <= '0;
      emit_cnt_r <= '0;
      idx_r      <= '0;
      sel_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) limit_r <= cfg_data;
      fill_r     <= fill_nxt;
      offered_r  <= offered_nxt;
      out_valid  <= out_valid_nxt;
      have_r     <= have_nxt;
      emitted_r  <= emitted_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      idx_r      <= idx_nxt;
      sel_r      <= sel_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sel_key_r  <= sel_key_nxt;
    cand_r     <= cand_nxt;
    out_item_r <= out_item_nxt;
    if (state_r == ST_IDLE && start) item_r <= in_item;
    if (wr_en) table_q[wr_idx] <= (state_r == ST_SCORE) ? cand_nxt : cand_r;
  end

  assign busy     = (state_r != ST_IDLE);
  assign out_item = out_item_r;
endmodule
`default_nettype wire
